[rtl/core/tcp_pkg.sv]
// package: types, codes and defaults shared by the text cursor placement core
`timescale 1ns / 1ps

package tcp_pkg;

	// configuration port
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [2:0] REG_AREA_LEFT   = 3'd0;
	localparam logic [2:0] REG_AREA_TOP    = 3'd1;
	localparam logic [2:0] REG_AREA_WIDTH  = 3'd2;
	localparam logic [2:0] REG_AREA_HEIGHT = 3'd3;
	localparam logic [2:0] REG_CELL_WIDTH  = 3'd4;
	localparam logic [2:0] REG_CELL_HEIGHT = 3'd5;

	localparam logic [10:0] RST_AREA_LEFT   = 11'd0;
	localparam logic [10:0] RST_AREA_TOP    = 11'd0;
	localparam logic [10:0] RST_AREA_WIDTH  = 11'd640;
	localparam logic [10:0] RST_AREA_HEIGHT = 11'd400;
	localparam logic [5:0]  RST_CELL_WIDTH  = 6'd8;
	localparam logic [5:0]  RST_CELL_HEIGHT = 6'd16;

	// control characters
	localparam logic [7:0] CH_BEL = 8'd7;
	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_HT  = 8'd9;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_FF  = 8'd12;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_DEL = 8'd127;
	localparam logic [7:0] CH_SP  = 8'd32;

	// a tab is this many spaces
	localparam int unsigned TAB_STEPS = 5;

	// queue depths
	localparam int unsigned CMD_DEPTH_DEF = 4;
	localparam int unsigned OUT_DEPTH_DEF = 4;

	typedef struct packed {
		logic [10:0] area_left;
		logic [10:0] area_top;
		logic [10:0] area_width;
		logic [10:0] area_height;
		logic [5:0]  cell_width;
		logic [5:0]  cell_height;
	} cfg_t;

	typedef enum logic [2:0] {
		CMD_DRAW,
		CMD_LF,
		CMD_CR,
		CMD_BELL,
		CMD_TAB,
		CMD_FF,
		CMD_BS
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] glyph;
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_DRAW   = 2'd0,
		ACT_SCROLL = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_BELL   = 2'd3
	} act_t;

	typedef struct packed {
		act_t        action;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  glyph;
		logic        last;
	} res_t;

	typedef enum logic [1:0] {
		BK_FETCH,
		BK_TAB,
		BK_SCROLL
	} bk_state_t;

endpackage

[rtl/core/tcp_cfg.sv]
// configuration register file behind the apb-style port
`timescale 1ns / 1ps

module tcp_cfg
	import tcp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.area_left   <= RST_AREA_LEFT;
			cfg_q.area_top    <= RST_AREA_TOP;
			cfg_q.area_width  <= RST_AREA_WIDTH;
			cfg_q.area_height <= RST_AREA_HEIGHT;
			cfg_q.cell_width  <= RST_CELL_WIDTH;
			cfg_q.cell_height <= RST_CELL_HEIGHT;
		end else if (wr_en) begin
			case (idx)
				REG_AREA_LEFT:   cfg_q.area_left   <= pwdata[10:0];
				REG_AREA_TOP:    cfg_q.area_top    <= pwdata[10:0];
				REG_AREA_WIDTH:  cfg_q.area_width  <= pwdata[10:0];
				REG_AREA_HEIGHT: cfg_q.area_height <= pwdata[10:0];
				REG_CELL_WIDTH:  cfg_q.cell_width  <= pwdata[5:0];
				REG_CELL_HEIGHT: cfg_q.cell_height <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_AREA_LEFT:   prdata = {21'd0, cfg_q.area_left};
			REG_AREA_TOP:    prdata = {21'd0, cfg_q.area_top};
			REG_AREA_WIDTH:  prdata = {21'd0, cfg_q.area_width};
			REG_AREA_HEIGHT: prdata = {21'd0, cfg_q.area_height};
			REG_CELL_WIDTH:  prdata = {26'd0, cfg_q.cell_width};
			REG_CELL_HEIGHT: prdata = {26'd0, cfg_q.cell_height};
			default:         prdata = '0;
		endcase
	end

endmodule

[rtl/core/tcp_front.sv]
// front end: byte classifier and command queue
`timescale 1ns / 1ps

module tcp_front
	import tcp_pkg::*;
#(
	parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       cmd_empty,
	output cmd_t       cmd_head,
	input  logic       cmd_pop
);

	localparam int unsigned PTR_W = $clog2(CMD_DEPTH);
	localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

	cmd_t             mem_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	cmd_t             cmd_in;
	logic             wr, rd;

	// classify
	always_comb begin
		cmd_in.glyph = rx_byte;
		case (rx_byte)
			CH_LF:   cmd_in.op = CMD_LF;
			CH_CR:   cmd_in.op = CMD_CR;
			CH_BEL:  cmd_in.op = CMD_BELL;
			CH_HT:   cmd_in.op = CMD_TAB;
			CH_FF:   cmd_in.op = CMD_FF;
			CH_BS:   cmd_in.op = CMD_BS;
			CH_DEL:  cmd_in.op = CMD_BS;
			default: cmd_in.op = CMD_DRAW;
		endcase
	end

	assign full      = (cnt_q == CNT_W'(CMD_DEPTH));
	assign cmd_empty = (cnt_q == '0);
	assign cmd_head  = mem_q[rd_ptr_q];
	assign wr        = push & ~full;
	assign rd        = cmd_pop & ~cmd_empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CMD_DEPTH))
		else $error("command queue count beyond depth");

endmodule

[rtl/core/tcp_back.sv]
// back end: cursor sequencer and result queue
`timescale 1ns / 1ps

module tcp_back
	import tcp_pkg::*;
#(
	parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_empty,
	input  cmd_t cmd_head,
	output logic cmd_pop,
	output logic empty,
	input  logic pop,
	output res_t res_head
);

	localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
	localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

	bk_state_t   st_q, st_d;
	logic [10:0] dx_q, dx_d, dy_q, dy_d;
	logic [2:0]  rem_q, rem_d;

	res_t             mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_full, wr, rd;
	res_t             res_in;

	logic        fit, wrap, scroll;
	logic [11:0] adv;
	logic [10:0] bs_nd, dy_down;
	logic [11:0] x_cur, y_cur, x_bs;
	logic        step_go, step_final;
	logic [7:0]  step_glyph;

	assign out_full = (cnt_q == CNT_W'(OUT_DEPTH));
	assign empty    = (cnt_q == '0);
	assign rd       = pop & ~empty;
	assign res_head = mem_q[rd_ptr_q];

	// cursor arithmetic
	assign fit     = (({1'b0, dy_q} + {5'd0, cfg.cell_height, 1'b0}) <= {1'b0, cfg.area_height});
	assign adv     = {1'b0, dx_q} + {6'd0, cfg.cell_width};
	assign wrap    = (({1'b0, adv} + {7'd0, cfg.cell_width}) > {2'b0, cfg.area_width});
	assign scroll  = wrap & ~fit;
	assign bs_nd   = (dx_q > {5'd0, cfg.cell_width}) ? dx_q - {5'd0, cfg.cell_width} : '0;
	assign dy_down = dy_q + {5'd0, cfg.cell_height};
	assign x_cur   = {1'b0, cfg.area_left} + {1'b0, dx_q};
	assign x_bs    = {1'b0, cfg.area_left} + {1'b0, bs_nd};
	assign y_cur   = {1'b0, cfg.area_top} + {1'b0, dy_q};

	always_comb begin
		st_d       = st_q;
		dx_d       = dx_q;
		dy_d       = dy_q;
		rem_d      = rem_q;
		cmd_pop    = 1'b0;
		wr         = 1'b0;
		res_in     = '0;
		step_go    = 1'b0;
		step_final = 1'b0;
		step_glyph = CH_SP;

		case (st_q)
			BK_FETCH: begin
				if (!cmd_empty && !out_full) begin
					cmd_pop = 1'b1;
					case (cmd_head.op)
						CMD_LF: begin
							if (fit) begin
								dy_d = dy_down;
							end else begin
								wr            = 1'b1;
								res_in.action = ACT_SCROLL;
								res_in.pos_y  = y_cur;
								res_in.last   = 1'b1;
							end
						end
						CMD_CR: dx_d = '0;
						CMD_BELL: begin
							wr            = 1'b1;
							res_in.action = ACT_BELL;
							res_in.last   = 1'b1;
						end
						CMD_FF: begin
							wr            = 1'b1;
							res_in.action = ACT_CLEAR;
							res_in.last   = 1'b1;
							dx_d          = '0;
							dy_d          = '0;
						end
						CMD_BS: begin
							if (dx_q != '0) begin
								dx_d          = bs_nd;
								wr            = 1'b1;
								res_in.action = ACT_DRAW;
								res_in.pos_x  = x_bs;
								res_in.pos_y  = y_cur;
								res_in.glyph  = CH_SP;
								res_in.last   = 1'b1;
							end
						end
						CMD_TAB: begin
							step_go = 1'b1;
							rem_d   = 3'(TAB_STEPS - 1);
						end
						default: begin
							step_go    = 1'b1;
							step_final = 1'b1;
							step_glyph = cmd_head.glyph;
							rem_d      = '0;
						end
					endcase
				end
			end
			BK_TAB: begin
				if (!out_full) begin
					step_go    = 1'b1;
					step_final = (rem_q == 3'd1);
					rem_d      = rem_q - 1'b1;
				end
			end
			BK_SCROLL: begin
				if (!out_full) begin
					wr            = 1'b1;
					res_in.action = ACT_SCROLL;
					res_in.pos_y  = y_cur;
					res_in.last   = (rem_q == '0);
					st_d          = (rem_q == '0) ? BK_FETCH : BK_TAB;
				end
			end
			default: st_d = BK_FETCH;
		endcase

		// one draw and advance step
		if (step_go) begin
			wr            = 1'b1;
			res_in.action = ACT_DRAW;
			res_in.pos_x  = x_cur;
			res_in.pos_y  = y_cur;
			res_in.glyph  = step_glyph;
			res_in.last   = step_final & ~scroll;
			if (wrap) begin
				dx_d = '0;
				if (fit) begin
					dy_d = dy_down;
				end
			end else begin
				dx_d = adv[10:0];
			end
			if (scroll) begin
				st_d = BK_SCROLL;
			end else begin
				st_d = (rem_d == '0) ? BK_FETCH : BK_TAB;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= BK_FETCH;
			dx_q  <= '0;
			dy_q  <= '0;
			rem_q <= '0;
		end else begin
			st_q  <= st_d;
			dx_q  <= dx_d;
			dy_q  <= dy_d;
			rem_q <= rem_d;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !out_full)
		else $error("result written into a full queue");

	a_fetch_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (st_q == BK_FETCH))
		else $error("command taken while a tab or scroll is pending");

	a_tab_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_TAB) |-> (rem_q != '0 && rem_q <= 3'(TAB_STEPS - 1)))
		else $error("tab step count out of range");

	a_scroll_after_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_SCROLL) |-> (dx_q == '0))
		else $error("scroll pending without a wrap");

endmodule

[rtl/core/text_cursor_placement_core.sv]
// top level: text cursor placement core for a glass terminal
`timescale 1ns / 1ps

// Received terminal bytes enter on a queue-style port (push/full) and drawing
// commands leave on another (empty/pop); each command carries an action
// (draw glyph, scroll one row, clear area, ring bell), absolute pixel x and y,
// the glyph and a last flag on the final command caused by a byte. A front
// end classifies each byte into a command and parks it in a small command
// queue; the back end holds the cursor offsets, works each command and writes
// results into a result queue, so input is taken every cycle while the
// command queue has room. The back end produces at most one result per cycle: line
// feed, carriage return, bell, form feed, backspace and an ordinary glyph
// give at most one result, a glyph that wraps and scrolls gives a draw and a
// scroll, and a tab gives five space draws, each possibly followed by a scroll;
// the sustained rate is set by that single result write per cycle and by how
// fast results are popped. Line feed and carriage return yield no result
// unless a scroll is needed, and backspace at the left edge yields nothing.
// The six registers sit at byte addresses 0, 4, ... 20 (area_left, area_top,
// area_width, area_height, cell_width, cell_height); the user must write them
// only while the core is idle (the core does not enforce it); pready is always high.

module text_cursor_placement_core
	import tcp_pkg::*;
#(
	parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF, // 2 and up
	parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF  // 2 and up
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// byte items in
	input  logic              push,
	output logic              full,
	input  logic [7:0]        rx_byte,
	// command items out
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        action,
	output logic [11:0]       pos_x,
	output logic [11:0]       pos_y,
	output logic [7:0]        glyph,
	output logic              last
);

	cfg_t cfg;
	cmd_t cmd_head;
	logic cmd_empty;
	logic cmd_pop;
	res_t res_head;

	// register file
	tcp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// classifier and command queue
	tcp_front #(
		.CMD_DEPTH (CMD_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop)
	);

	// cursor sequencer and result queue
	tcp_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.res_head  (res_head)
	);

	// oldest result on the ports
	assign action = res_head.action;
	assign pos_x  = res_head.pos_x;
	assign pos_y  = res_head.pos_y;
	assign glyph  = res_head.glyph;
	assign last   = res_head.last;

endmodule

[bench/tb_text_cursor_placement_core.sv]
// testbench for the text cursor placement core: directed table, then random bytes and settings
`timescale 1ns / 1ps

module tb_text_cursor_placement_core
	import tcp_pkg::*;
();

	// cycles allowed after the last expected command, for bytes that make no command
	localparam int unsigned SETTLE_CYCLES = 16;
	// time limit for the whole run, about ten times the worst run
	localparam int unsigned LIMIT_NS      = 4_800_000;
	localparam int unsigned PHASE_ITEMS   = 25;
	localparam int unsigned PHASE_COUNT   = 8;
	localparam int unsigned REPORT_LINES  = 30;
	// register slots past the last real register, writes there must change nothing
	localparam int unsigned REG_SPARE_A   = 6;
	localparam int unsigned REG_SPARE_B   = 7;

	typedef enum {ROW_ITEM, ROW_WRITE} row_kind_t;
	typedef enum {MODE_SMALL, MODE_MAX, MODE_MIN, MODE_RAW, MODE_TYPICAL} cfg_mode_t;

	// one line of the directed table: a byte item or a register write
	typedef struct {
		row_kind_t   kind;
		logic [7:0]  ch;
		int unsigned idx;
		logic [31:0] val;
		bit          typed;
		res_t        cmd;
	} row_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              push    = 1'b0;
	logic              full;
	logic [7:0]        rx_byte = '0;
	logic              empty;
	logic              pop     = 1'b0;
	logic [1:0]        action;
	logic [11:0]       pos_x;
	logic [11:0]       pos_y;
	logic [7:0]        glyph;
	logic              last;

	text_cursor_placement_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.rx_byte (rx_byte),
		.empty   (empty),
		.pop     (pop),
		.action  (action),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.glyph   (glyph),
		.last    (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// bench copy of the register file and of the cursor offsets
	logic [10:0] cfg_left   = RST_AREA_LEFT;
	logic [10:0] cfg_top    = RST_AREA_TOP;
	logic [10:0] cfg_width  = RST_AREA_WIDTH;
	logic [10:0] cfg_height = RST_AREA_HEIGHT;
	logic [5:0]  cfg_cw     = RST_CELL_WIDTH;
	logic [5:0]  cfg_ch     = RST_CELL_HEIGHT;
	int unsigned cur_dx     = 0;
	int unsigned cur_dy     = 0;

	res_t pending_cmds[$];   // commands still owed by the core, oldest first
	res_t byte_cmds[$];      // commands worked out for the byte just taken
	int   mismatches = 0;
	bit   quiet      = 1'b0; // no idling on either side once set

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= REPORT_LINES)
			$display("%0t ns: %s", $time, what);
	endtask

	function automatic void add_cmd(act_t a, int unsigned x, int unsigned y, logic [7:0] g);
		res_t r;
		r.action = a;
		r.pos_x  = x[11:0];
		r.pos_y  = y[11:0];
		r.glyph  = g;
		r.last   = 1'b0;
		byte_cmds.push_back(r);
	endfunction

	// down one cell row if the next row still fits, else scroll and stay
	function automatic void next_row();
		if (cur_dy + 2 * cfg_ch > cfg_height)
			add_cmd(ACT_SCROLL, 0, cfg_top + cur_dy, 8'd0);
		else
			cur_dy = (cur_dy + cfg_ch) & 32'h7FF;
	endfunction

	// draw at the cursor, advance, and wrap to the next row when the cell after won't fit
	function automatic void draw_cell(logic [7:0] g);
		add_cmd(ACT_DRAW, cfg_left + cur_dx, cfg_top + cur_dy, g);
		cur_dx = cur_dx + cfg_cw;
		if (cur_dx + cfg_cw > cfg_width) begin
			cur_dx = 0;
			next_row();
		end
		cur_dx = cur_dx & 32'h7FF;
	endfunction

	// commands caused by one received byte, with the cursor moved on
	function automatic void place_cursor(logic [7:0] b);
		byte_cmds.delete();
		case (b)
			CH_LF:  next_row();
			CH_CR:  cur_dx = 0;
			CH_BEL: add_cmd(ACT_BELL, 0, 0, 8'd0);
			CH_HT: begin
				for (int i = 0; i < TAB_STEPS; i++)
					draw_cell(CH_SP);
			end
			CH_FF: begin
				add_cmd(ACT_CLEAR, 0, 0, 8'd0);
				cur_dx = 0;
				cur_dy = 0;
			end
			CH_BS, CH_DEL: begin
				// nothing at the left edge; short of a full cell it clamps to zero
				if (cur_dx > 0) begin
					cur_dx = (cur_dx > cfg_cw) ? cur_dx - cfg_cw : 0;
					add_cmd(ACT_DRAW, cfg_left + cur_dx, cfg_top + cur_dy, CH_SP);
				end
			end
			default: draw_cell(b);
		endcase
		if (byte_cmds.size() > 0)
			byte_cmds[byte_cmds.size() - 1].last = 1'b1;
	endfunction

	function automatic res_t mk_cmd(act_t a, logic [11:0] x, logic [11:0] y, logic [7:0] g);
		res_t r;
		r.action = a;
		r.pos_x  = x;
		r.pos_y  = y;
		r.glyph  = g;
		r.last   = 1'b1;
		return r;
	endfunction

	function automatic row_t row_item(logic [7:0] b);
		row_t r;
		r.kind  = ROW_ITEM;
		r.ch    = b;
		r.idx   = 0;
		r.val   = '0;
		r.typed = 1'b0;
		r.cmd   = '0;
		return r;
	endfunction

	function automatic row_t row_known(logic [7:0] b, res_t cmd);
		row_t r;
		r       = row_item(b);
		r.typed = 1'b1;
		r.cmd   = cmd;
		return r;
	endfunction

	function automatic row_t row_write(int unsigned idx, logic [31:0] v);
		row_t r;
		r      = row_item(8'd0);
		r.kind = ROW_WRITE;
		r.idx  = idx;
		r.val  = v;
		return r;
	endfunction

	// printable text in 45 of 100 picks, the rest raw bytes and every control code
	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 8'($urandom_range(32, 126));
		else if (r < 57)
			return 8'($urandom_range(0, 255));
		else if (r < 66)
			return CH_HT;
		else if (r < 71)
			return CH_BS;
		else if (r < 75)
			return CH_DEL;
		else if (r < 84)
			return CH_LF;
		else if (r < 91)
			return CH_CR;
		else if (r < 95)
			return CH_BEL;
		else if (r < 97)
			return CH_FF;
		return 8'($urandom_range(128, 255));
	endfunction

	// register write: setup phase, then access phase until pready, then psel dropped while idle
	task automatic cfg_write(int unsigned idx, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 4);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_AREA_LEFT:   cfg_left   = v[10:0];
			REG_AREA_TOP:    cfg_top    = v[10:0];
			REG_AREA_WIDTH:  cfg_width  = v[10:0];
			REG_AREA_HEIGHT: cfg_height = v[10:0];
			REG_CELL_WIDTH:  cfg_cw     = v[5:0];
			REG_CELL_HEIGHT: cfg_ch     = v[5:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// register read, compared with the bench copy
	task automatic cfg_check(int unsigned idx);
		logic [31:0] want;
		case (idx)
			REG_AREA_LEFT:   want = 32'(cfg_left);
			REG_AREA_TOP:    want = 32'(cfg_top);
			REG_AREA_WIDTH:  want = 32'(cfg_width);
			REG_AREA_HEIGHT: want = 32'(cfg_height);
			REG_CELL_WIDTH:  want = 32'(cfg_cw);
			REG_CELL_HEIGHT: want = 32'(cfg_ch);
			default:         want = '0;
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// offer one byte and hold it until taken; push stays high for a following item
	task automatic send_byte(logic [7:0] b, bit typed, res_t typed_cmd);
		push    <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		place_cursor(b);
		if (typed)
			pending_cmds.push_back(typed_cmd);
		else
			foreach (byte_cmds[i])
				pending_cmds.push_back(byte_cmds[i]);
	endtask

	// occasional gap with push low
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// stop sending, drain every owed command, then let bytes without commands work through
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver: pop stalls in random bursts, none once quiet
	int unsigned pop_hold = 0;
	always @(posedge clk) begin
		if (quiet) begin
			pop <= 1'b1;
		end else if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop      <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			pop_hold <= $urandom_range(0, 6);
			pop      <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// every command taken is checked field by field against the oldest one owed
	always @(posedge clk) begin : cmd_check
		res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_cmds.size() == 0) begin
				report_mismatch($sformatf("command %0d x=%0d y=%0d g=%0d with none owed",
					action, pos_x, pos_y, glyph));
			end else begin
				want = pending_cmds.pop_front();
				if (action !== want.action)
					report_mismatch($sformatf("action %0d, want %0d", action, want.action));
				if (pos_x !== want.pos_x)
					report_mismatch($sformatf("pos_x %0d, want %0d", pos_x, want.pos_x));
				if (pos_y !== want.pos_y)
					report_mismatch($sformatf("pos_y %0d, want %0d", pos_y, want.pos_y));
				if (glyph !== want.glyph)
					report_mismatch($sformatf("glyph %0d, want %0d", glyph, want.glyph));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", last, want.last));
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		row_t        rows[$];
		cfg_mode_t   phase_modes[PHASE_COUNT];
		logic [31:0] vals[6];

		phase_modes = '{MODE_SMALL, MODE_MAX, MODE_RAW, MODE_MIN,
			MODE_SMALL, MODE_RAW, MODE_TYPICAL, MODE_SMALL};

		// after reset: 640 x 400 area at the origin, 8 x 16 cells
		rows.push_back(row_known(8'h41, mk_cmd(ACT_DRAW, 0, 0, 8'h41)));
		rows.push_back(row_known(CH_BEL, mk_cmd(ACT_BELL, 0, 0, 0)));
		rows.push_back(row_known(8'h00, mk_cmd(ACT_DRAW, 8, 0, 8'h00)));
		rows.push_back(row_known(8'hFF, mk_cmd(ACT_DRAW, 16, 0, 8'hFF)));
		rows.push_back(row_known(CH_BS, mk_cmd(ACT_DRAW, 16, 0, CH_SP)));
		rows.push_back(row_item(CH_CR));
		// erase at the left edge gives nothing
		rows.push_back(row_item(CH_DEL));
		rows.push_back(row_item(CH_LF));
		rows.push_back(row_item(CH_HT));
		rows.push_back(row_known(CH_FF, mk_cmd(ACT_CLEAR, 0, 0, 0)));
		rows.push_back(row_known(8'h78, mk_cmd(ACT_DRAW, 0, 0, 8'h78)));
		// cell now wider than the cursor offset, so backspace clamps to the edge
		rows.push_back(row_write(REG_CELL_WIDTH, 32'd20));
		rows.push_back(row_known(CH_BS, mk_cmd(ACT_DRAW, 0, 0, CH_SP)));
		// 2 x 2 cells placed at the far corner: wraps, scrolls and 12-bit positions
		rows.push_back(row_write(REG_AREA_LEFT, 32'd2047));
		rows.push_back(row_write(REG_AREA_TOP, 32'd2047));
		rows.push_back(row_write(REG_AREA_WIDTH, 32'd40));
		rows.push_back(row_write(REG_AREA_HEIGHT, 32'd40));
		rows.push_back(row_write(REG_CELL_HEIGHT, 32'd20));
		rows.push_back(row_item(8'h61));
		rows.push_back(row_item(8'h62));
		rows.push_back(row_item(8'h63));
		rows.push_back(row_item(8'h64));
		rows.push_back(row_item(CH_LF));
		rows.push_back(row_item(CH_HT));
		// oversized values keep their low bits: zero cells and a zero-width area
		rows.push_back(row_write(REG_CELL_WIDTH, 32'h0000_0040));
		rows.push_back(row_write(REG_CELL_HEIGHT, 32'hFFFF_FFC0));
		rows.push_back(row_write(REG_AREA_WIDTH, 32'h0000_0800));
		rows.push_back(row_write(REG_AREA_HEIGHT, 32'hFFFF_F7FF));
		rows.push_back(row_item(8'h7E));
		rows.push_back(row_item(CH_BS));
		rows.push_back(row_item(CH_LF));
		// writes past the last register are dropped
		rows.push_back(row_write(REG_SPARE_A, 32'hFFFF_FFFF));
		rows.push_back(row_write(REG_SPARE_B, 32'hFFFF_FFFF));
		rows.push_back(row_item(8'h71));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE) begin
				wait_idle();
				cfg_write(rows[i].idx, rows[i].val);
			end else begin
				sender_gap();
				send_byte(rows[i].ch, rows[i].typed, rows[i].cmd);
			end
		end

		// random phases, each under a fresh setting of all six registers
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_idle();
			if (p == PHASE_COUNT - 1)
				quiet <= 1'b1;
			case (phase_modes[p])
				MODE_SMALL: vals = '{$urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(1, 80), $urandom_range(1, 80),
					$urandom_range(1, 32), $urandom_range(1, 32)};
				MODE_MAX:   vals = '{2047, 2047, 2047, 2047, 32, 32};
				MODE_MIN:   vals = '{0, 0, 1, 1, 1, 1};
				MODE_RAW:   vals = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
				default:    vals = '{$urandom_range(0, 200), $urandom_range(0, 200),
					$urandom_range(200, 2047), $urandom_range(200, 2047),
					$urandom_range(4, 16), $urandom_range(8, 24)};
			endcase
			for (int r = REG_AREA_LEFT; r <= REG_CELL_HEIGHT; r++)
				cfg_write(r, vals[r]);
			for (int r = REG_AREA_LEFT; r <= REG_CELL_HEIGHT; r++)
				cfg_check(r);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// once mid-run the sender holds off until the core has drained
				if (p == 2 && n == PHASE_ITEMS / 2)
					wait_idle();
				sender_gap();
				send_byte(pick_byte(), 1'b0, '0);
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
